// File: rtl/aamr_pkg.sv
// shared constants, types and the arctangent table of the axis-angle rotator
// depends on nothing; used by aamr_coef_build and axis_angle_matrix_rotate
package aamr_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 20;
    localparam int ANGLE_FRAC   = 30;
    localparam int TABLE_LEN    = 30;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int ITER_W       = $clog2(CORDIC_ITERS);

    localparam int DATA_W  = 32;
    localparam int ANGLE_W = 19;
    localparam int AXIS_W  = 18;
    localparam int CFG_W   = 19;
    localparam int COEF_W  = 26;
    localparam int TDATA_W = 4 * DATA_W;

    typedef logic signed [COEF_W-1:0] coef_t;

    typedef enum logic [1:0] {
        REG_ANGLE  = 2'd0,
        REG_AXIS_X = 2'd1,
        REG_AXIS_Y = 2'd2,
        REG_AXIS_Z = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic signed [AXIS_W-1:0]  ax;
        logic signed [AXIS_W-1:0]  ay;
        logic signed [AXIS_W-1:0]  az;
    } rot_cfg_t;

    // atan(2^-i) in q0.30, truncated but for the last three entries, which are rounded
    function automatic logic [29:0] atan_q30(input logic [ITER_W-1:0] i);
        logic [29:0] r;
        unique case (5'(i))
            5'd0:  r = 30'd843314856;
            5'd1:  r = 30'd497837829;
            5'd2:  r = 30'd263043836;
            5'd3:  r = 30'd133525158;
            5'd4:  r = 30'd67021686;
            5'd5:  r = 30'd33543515;
            5'd6:  r = 30'd16775850;
            5'd7:  r = 30'd8388437;
            5'd8:  r = 30'd4194282;
            5'd9:  r = 30'd2097149;
            5'd10: r = 30'd1048575;
            5'd11: r = 30'd524287;
            5'd12: r = 30'd262143;
            5'd13: r = 30'd131071;
            5'd14: r = 30'd65535;
            5'd15: r = 30'd32767;
            5'd16: r = 30'd16383;
            5'd17: r = 30'd8191;
            5'd18: r = 30'd4095;
            5'd19: r = 30'd2047;
            5'd20: r = 30'd1023;
            5'd21: r = 30'd511;
            5'd22: r = 30'd255;
            5'd23: r = 30'd127;
            5'd24: r = 30'd63;
            5'd25: r = 30'd31;
            5'd26: r = 30'd15;
            5'd27: r = 30'd8;
            5'd28: r = 30'd4;
            5'd29: r = 30'd2;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/aamr_coef_build.sv
// rotation matrix builder: iterative cordic, then nine coefficients one by one
// depends on aamr_pkg
module aamr_coef_build (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  aamr_pkg::rot_cfg_t cfg,
    output logic              busy,
    output aamr_pkg::coef_t   coef [0:2][0:2]
);
    import aamr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_INIT, ST_ROT, ST_SCALE, ST_PROD, ST_ACC
    } state_t;

    localparam int SH = ANGLE_FRAC - FRAC_BITS;
    localparam logic signed [32:0] PI_Q30      = 33'sd3373259426;
    localparam logic signed [32:0] HALF_PI_Q30 = 33'sd1686629713;
    localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;
    localparam logic signed [31:0] HALF_SH     = 32'sd1 <<< (SH - 1);
    localparam logic signed [19:0] ONE_Q       = 20'sd1 <<< FRAC_BITS;

    state_t                    state_reg;
    logic [ITER_W-1:0]         iter_reg;
    logic signed [31:0]        z_reg, cx_reg, cy_reg;
    logic                      flip_reg;
    logic signed [19:0]        c_reg, s_reg, k_reg;
    logic [1:0]                row_reg, col_reg;
    logic signed [19:0]        p_reg;
    logic signed [22:0]        t_reg;
    coef_t                     coef_reg [0:2][0:2];

    logic signed [32:0]        z_in, z_clamp;
    logic signed [31:0]        cxf, cyf, c_full, s_full;
    logic signed [AXIS_W-1:0]  u_op, v_op, w_op;
    logic signed [35:0]        uv_prod;
    logic signed [37:0]        ws_prod;
    logic signed [39:0]        pk_prod;
    logic signed [19:0]        p_next;
    logic signed [21:0]        ws_round;
    logic signed [22:0]        t_next;
    logic signed [23:0]        q_round;
    logic signed [24:0]        coef_sum;
    logic                      neg_term;
    logic [1:0]                other_idx;

    function automatic logic signed [AXIS_W-1:0] pick(input logic [1:0] n,
                                                      input rot_cfg_t r);
        logic signed [AXIS_W-1:0] v;
        unique case (n)
            2'd0:    v = r.ax;
            2'd1:    v = r.ay;
            default: v = r.az;
        endcase
        return v;
    endfunction

    always_comb
    begin
        z_in = 33'(cfg.angle) <<< SH;
        if (z_in > PI_Q30)
            z_clamp = PI_Q30;
        else if (z_in < -PI_Q30)
            z_clamp = -PI_Q30;
        else
            z_clamp = z_in;

        cxf    = flip_reg ? -cx_reg : cx_reg;
        cyf    = flip_reg ? -cy_reg : cy_reg;
        c_full = (cxf + HALF_SH) >>> SH;
        s_full = (cyf + HALF_SH) >>> SH;

        // the third axis index, for the cross-product term
        other_idx = 2'(3 - 32'(row_reg) - 32'(col_reg));
        neg_term  = (col_reg == ((row_reg == 2'd2) ? 2'd0 : row_reg + 2'd1));
        u_op = pick(row_reg, cfg);
        v_op = pick(col_reg, cfg);
        w_op = pick(other_idx, cfg);

        uv_prod  = 36'(u_op) * 36'(v_op);
        p_next   = 20'((uv_prod + (36'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        ws_prod  = 38'(w_op) * 38'(s_reg);
        ws_round = 22'((ws_prod + (38'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        if (row_reg == col_reg)
            t_next = 23'(c_reg);
        else if (neg_term)
            t_next = -23'(ws_round);
        else
            t_next = 23'(ws_round);

        pk_prod  = 40'(p_reg) * 40'(k_reg);
        q_round  = 24'((pk_prod + (40'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        coef_sum = 25'(q_round) + 25'(t_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            z_reg     <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            flip_reg  <= 1'b0;
            c_reg     <= '0;
            s_reg     <= '0;
            k_reg     <= '0;
            p_reg     <= '0;
            t_reg     <= '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    coef_reg[r][k] <= (r == k) ? (coef_t'(1) <<< FRAC_BITS) : '0;
                end
            end
        end
        else if (start)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                end
                ST_INIT:
                begin
                    // fold the angle into -pi/2..pi/2, remember the sign flip
                    if (z_clamp > HALF_PI_Q30)
                    begin
                        z_reg    <= 32'(z_clamp - PI_Q30);
                        flip_reg <= 1'b1;
                    end
                    else if (z_clamp < -HALF_PI_Q30)
                    begin
                        z_reg    <= 32'(z_clamp + PI_Q30);
                        flip_reg <= 1'b1;
                    end
                    else
                    begin
                        z_reg    <= 32'(z_clamp);
                        flip_reg <= 1'b0;
                    end
                    cx_reg    <= GAIN_Q30;
                    cy_reg    <= '0;
                    iter_reg  <= '0;
                    state_reg <= ST_ROT;
                end
                ST_ROT:
                begin
                    if (z_reg >= 0)
                    begin
                        cx_reg <= cx_reg - (cy_reg >>> iter_reg);
                        cy_reg <= cy_reg + (cx_reg >>> iter_reg);
                        z_reg  <= z_reg - $signed({2'b00, atan_q30(iter_reg)});
                    end
                    else
                    begin
                        cx_reg <= cx_reg + (cy_reg >>> iter_reg);
                        cy_reg <= cy_reg - (cx_reg >>> iter_reg);
                        z_reg  <= z_reg + $signed({2'b00, atan_q30(iter_reg)});
                    end
                    if (iter_reg == ITER_W'(CORDIC_ITERS - 1))
                        state_reg <= ST_SCALE;
                    else
                        iter_reg <= iter_reg + 1'b1;
                end
                ST_SCALE:
                begin
                    c_reg     <= 20'(c_full);
                    s_reg     <= 20'(s_full);
                    k_reg     <= ONE_Q - 20'(c_full);
                    row_reg   <= '0;
                    col_reg   <= '0;
                    state_reg <= ST_PROD;
                end
                ST_PROD:
                begin
                    p_reg     <= p_next;
                    t_reg     <= t_next;
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    coef_reg[row_reg][col_reg] <= coef_t'(coef_sum);
                    if (col_reg == 2'd2)
                    begin
                        col_reg <= '0;
                        if (row_reg == 2'd2)
                        begin
                            row_reg   <= '0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            row_reg   <= row_reg + 1'b1;
                            state_reg <= ST_PROD;
                        end
                    end
                    else
                    begin
                        col_reg   <= col_reg + 1'b1;
                        state_reg <= ST_PROD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign coef = coef_reg;

endmodule

// File: rtl/axis_angle_matrix_rotate.sv
// an accepted item passes the capture, product, sum and output registers to m_axis
// throughput: one row item per cycle while streaming; an output stall holds in the same
// cycle each full stage with no empty stage after it, while the others keep moving
// a register write rebuilds the 3x3 matrix (cordic, then nine coefficients),
// during which s_axis_tready is low
// reset: asynchronous active low; registers go to angle 0, axis (0,0,1), matrix identity
module axis_angle_matrix_rotate (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_addr,
    input  logic [aamr_pkg::CFG_W-1:0]    cfg_data,
    // input rows
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [aamr_pkg::TDATA_W-1:0]  s_axis_tdata,  // row_a, row_b, row_c, row_shift
    input  logic                          s_axis_tlast,  // final_row
    // rotated rows
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [aamr_pkg::TDATA_W-1:0]  m_axis_tdata,  // out_a, out_b, out_c, out_shift
    output logic                          m_axis_tlast   // out_final
);
    import aamr_pkg::*;

    localparam int PROD_W = DATA_W + COEF_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SUM_W-FRAC_BITS-1:0] SAT_MAX = (SUM_W-FRAC_BITS)'(32'h7fffffff);
    localparam logic signed [SUM_W-FRAC_BITS-1:0] SAT_MIN = -SAT_MAX - 1'b1;

    // configuration registers
    rot_cfg_t  cfg_reg;
    logic      busy;
    coef_t     coef [0:2][0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle <= '0;
            cfg_reg.ax    <= '0;
            cfg_reg.ay    <= '0;
            cfg_reg.az    <= AXIS_W'(1) <<< FRAC_BITS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_ANGLE:  cfg_reg.angle <= cfg_data[ANGLE_W-1:0];
                REG_AXIS_X: cfg_reg.ax    <= cfg_data[AXIS_W-1:0];
                REG_AXIS_Y: cfg_reg.ay    <= cfg_data[AXIS_W-1:0];
                REG_AXIS_Z: cfg_reg.az    <= cfg_data[AXIS_W-1:0];
                default:    cfg_reg       <= cfg_reg;
            endcase
        end
    end

    // every write restarts the matrix rebuild from the new register set
    aamr_coef_build u_build (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_we),
        .cfg   (cfg_reg),
        .busy  (busy),
        .coef  (coef)
    );

    // four stage pipeline: capture, products, column sums, round and saturate
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    logic signed [DATA_W-1:0] row_reg [0:2];
    logic [DATA_W-1:0]        sh1_reg, sh2_reg, sh3_reg, sh4_reg;
    logic                     l1_reg, l2_reg, l3_reg, l4_reg;
    logic signed [PROD_W-1:0] prod_reg [0:2][0:2];
    logic signed [SUM_W-1:0]  sum_reg [0:2];
    logic signed [DATA_W-1:0] out_reg [0:2];

    logic signed [SUM_W-FRAC_BITS-1:0] shifted [0:2];

    assign adv4 = !v4_reg || m_axis_tready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    // no new row while the matrix is being rebuilt
    assign s_axis_tready = adv1 && !busy && !cfg_we;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            shifted[j] = (SUM_W-FRAC_BITS)'(sum_reg[j] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= s_axis_tvalid && s_axis_tready;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                row_reg[i] <= s_axis_tdata[i*DATA_W +: DATA_W];
            end
            sh1_reg <= s_axis_tdata[3*DATA_W +: DATA_W];
            l1_reg  <= s_axis_tlast;
        end
        if (adv2)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= PROD_W'(row_reg[i]) * PROD_W'(coef[i][j]);
                end
            end
            sh2_reg <= sh1_reg;
            l2_reg  <= l1_reg;
        end
        if (adv3)
        begin
            // rounding half folded into the column sum
            for (int j = 0; j < 3; j++)
            begin
                sum_reg[j] <= SUM_W'(prod_reg[0][j]) + SUM_W'(prod_reg[1][j])
                            + SUM_W'(prod_reg[2][j]) + HALF;
            end
            sh3_reg <= sh2_reg;
            l3_reg  <= l2_reg;
        end
        if (adv4)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (shifted[j] > SAT_MAX)
                    out_reg[j] <= DATA_W'(SAT_MAX);
                else if (shifted[j] < SAT_MIN)
                    out_reg[j] <= DATA_W'(SAT_MIN);
                else
                    out_reg[j] <= DATA_W'(shifted[j]);
            end
            sh4_reg <= sh3_reg;
            l4_reg  <= l3_reg;
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = {sh4_reg, out_reg[2], out_reg[1], out_reg[0]};
    assign m_axis_tlast  = l4_reg;

endmodule
